// ===== rtl/prp_pkg.sv =====
// ----------------------------------------------------------------------------
// prp_pkg: shared constants and types for the point rotate and project block
// Screen geometry, fixed-point widths and configuration register indexes.
// ----------------------------------------------------------------------------
package prp_pkg;

    localparam int SCREEN_WIDTH  = 36;
    localparam int SCREEN_HEIGHT = 200;
    localparam int FOCAL_LENGTH  = 200;
    localparam int FRAC_BITS     = 14;

    localparam int COORD_W = 16;
    localparam int COEF_W  = 16;
    localparam int NUM_REGS = 8;
    localparam int REG_IDX_W = 3;

    // Coordinate widths after each rotation: two products summed, then
    // shifted right by the fraction width.
    localparam int PROD1_W = COORD_W + COEF_W;
    localparam int ROT1_W  = PROD1_W + 1 - FRAC_BITS;
    localparam int PROD2_W = ROT1_W + COEF_W;
    localparam int ROT2_W  = PROD2_W + 1 - FRAC_BITS;
    localparam int PROD3_W = ROT2_W + COEF_W;
    localparam int ROT3_W  = PROD3_W + 1 - FRAC_BITS;

    localparam int DEPTH_W = ROT3_W + 1;
    localparam int NUM_W   = ROT3_W + 2 + 10;
    localparam int CMP_W   = NUM_W + 1;

    // Visible screen window.
    localparam int X_MIN = 2;
    localparam int X_MAX = SCREEN_WIDTH;
    localparam int Y_MIN = 0;
    localparam int Y_MAX = SCREEN_HEIGHT;

    // Window expressed as bounds on the quotient before the centre offset.
    localparam int QX_LO    = X_MIN - SCREEN_WIDTH / 2;
    localparam int QX_HI_P1 = X_MAX - SCREEN_WIDTH / 2 + 1;
    localparam int QY_LO    = Y_MIN - SCREEN_HEIGHT / 2;
    localparam int QY_HI_P1 = Y_MAX - SCREEN_HEIGHT / 2 + 1;

    localparam int Q_BITS = 8;
    localparam int REM_W  = DEPTH_W + Q_BITS;

    localparam int SX_W = 6;
    localparam int SY_W = 8;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COS_X  = 3'd0,
        REG_SIN_X  = 3'd1,
        REG_COS_Y  = 3'd2,
        REG_SIN_Y  = 3'd3,
        REG_COS_Z  = 3'd4,
        REG_SIN_Z  = 3'd5,
        REG_CAM_Z  = 3'd6,
        REG_NEAR   = 3'd7
    } reg_idx_t;

    typedef logic signed [COEF_W-1:0] coef_t;

endpackage

// ===== rtl/point_rotate_project.sv =====
// ----------------------------------------------------------------------------
// point_rotate_project: rotate a 3D point about X, Y, Z and project it
// Fixed-point rotation with configured sine/cosine pairs, perspective divide
// and screen clip through a deep pipeline; one point per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel   | signals                              | direction
//  ----------+--------------------------------------+----------
//  vertex    | vert_valid vert_stall vert_x/y/z     | in
//  pixel     | pix_valid pix_stall on_screen sx sy  | out
//  config    | cfg_we cfg_index cfg_data            | in
//
// A word passes through three rotation stage pairs, three projection stages, the
// eight-stage restoring divider and the output register; a new word can enter
// every cycle while the output is not stalled.
// Reset clears the valid bits and loads the register defaults.
// A stalled output word holds the whole pipeline; nothing is dropped.
module point_rotate_project (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 vert_valid,
    output logic                                 vert_stall,
    input  logic signed [prp_pkg::COORD_W-1:0]   vert_x,
    input  logic signed [prp_pkg::COORD_W-1:0]   vert_y,
    input  logic signed [prp_pkg::COORD_W-1:0]   vert_z,
    output logic                                 pix_valid,
    input  logic                                 pix_stall,
    output logic                                 on_screen,
    output logic [prp_pkg::SX_W-1:0]             screen_x,
    output logic [prp_pkg::SY_W-1:0]             screen_y,
    input  logic                                 cfg_we,
    input  logic [prp_pkg::REG_IDX_W-1:0]        cfg_index,
    input  logic [prp_pkg::COEF_W-1:0]           cfg_data
);

    localparam int NSTAGE = 9 + prp_pkg::Q_BITS + 1;
    localparam int PW1 = prp_pkg::PROD1_W;
    localparam int PW2 = prp_pkg::PROD2_W;
    localparam int PW3 = prp_pkg::PROD3_W;
    localparam int R1 = prp_pkg::ROT1_W;
    localparam int R2 = prp_pkg::ROT2_W;
    localparam int R3 = prp_pkg::ROT3_W;
    localparam int FB = prp_pkg::FRAC_BITS;
    localparam int NW = prp_pkg::NUM_W;
    localparam int CW = prp_pkg::CMP_W;
    localparam int DW = prp_pkg::DEPTH_W;
    localparam int RW = prp_pkg::REM_W;
    localparam int QB = prp_pkg::Q_BITS;

    // Configuration registers.
    prp_pkg::coef_t cfg_reg [prp_pkg::NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[prp_pkg::REG_COS_X] <= 16'sd16384;
            cfg_reg[prp_pkg::REG_SIN_X] <= 16'sd0;
            cfg_reg[prp_pkg::REG_COS_Y] <= 16'sd16384;
            cfg_reg[prp_pkg::REG_SIN_Y] <= 16'sd0;
            cfg_reg[prp_pkg::REG_COS_Z] <= 16'sd16384;
            cfg_reg[prp_pkg::REG_SIN_Z] <= 16'sd0;
            cfg_reg[prp_pkg::REG_CAM_Z] <= -16'sd150;
            cfg_reg[prp_pkg::REG_NEAR]  <= 16'sd100;
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= prp_pkg::coef_t'(cfg_data);
        end
    end

    // Pipeline control: every stage moves together unless the output is held.
    logic [NSTAGE-1:0] v_reg;
    logic              adv;

    assign adv        = !(v_reg[NSTAGE-1] && pix_stall);
    assign vert_stall = !adv;
    assign pix_valid  = v_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NSTAGE-2:0], vert_valid};
        end
    end

    // Stage 1/2: rotation about X.
    logic signed [PW1-1:0] p1a_reg, p1b_reg, p1c_reg, p1d_reg;
    logic signed [prp_pkg::COORD_W-1:0] x1_reg;
    logic signed [PW1:0]   s1a_next, s1b_next;
    logic signed [R1-1:0]  y2_reg, z2_reg;
    logic signed [prp_pkg::COORD_W-1:0] x2_reg;

    assign s1a_next = (PW1+1)'(p1a_reg) - (PW1+1)'(p1b_reg);
    assign s1b_next = (PW1+1)'(p1c_reg) + (PW1+1)'(p1d_reg);

    // Stage 3/4: rotation about Y.
    logic signed [PW2-1:0] p3a_reg, p3b_reg, p3c_reg, p3d_reg;
    logic signed [R1-1:0]  y3_reg;
    logic signed [PW2:0]   s3a_next, s3b_next;
    logic signed [R2-1:0]  z4_reg, x4_reg;
    logic signed [R1-1:0]  y4_reg;

    assign s3a_next = (PW2+1)'(p3a_reg) - (PW2+1)'(p3b_reg);
    assign s3b_next = (PW2+1)'(p3c_reg) + (PW2+1)'(p3d_reg);

    // Stage 5/6: rotation about Z.
    logic signed [PW3-1:0] p5a_reg, p5b_reg, p5c_reg, p5d_reg;
    logic signed [R2-1:0]  z5_reg;
    logic signed [PW3:0]   s5a_next, s5b_next;
    logic signed [R3-1:0]  x6_reg, y6_reg;
    logic signed [R2-1:0]  z6_reg;

    assign s5a_next = (PW3+1)'(p5a_reg) - (PW3+1)'(p5b_reg);
    assign s5b_next = (PW3+1)'(p5c_reg) + (PW3+1)'(p5d_reg);

    // Stage 7: depth, near test and numerators.
    logic signed [DW-1:0] depth_next;
    logic signed [DW-1:0] depth7_reg;
    logic                 ok7_reg;
    logic signed [NW-1:0] nx7_reg, ny7_reg;

    assign depth_next = DW'(z6_reg) - DW'(cfg_reg[prp_pkg::REG_CAM_Z]);

    // Stage 8: window bounds scaled by depth.
    logic signed [CW-1:0] de7;
    logic signed [CW-1:0] xlo8_reg, xhi8_reg, ylo8_reg, yhi8_reg;
    logic signed [NW-1:0] nx8_reg, ny8_reg;
    logic [DW-1:0]        d8_reg;
    logic                 ok8_reg;

    assign de7 = CW'(depth7_reg);

    // Stage 9: range checks and offset numerators for the divider.
    logic signed [CW-1:0] nxe8, nye8, rx_next, ry_next;
    logic                 in_next;

    assign nxe8    = CW'(nx8_reg);
    assign nye8    = CW'(ny8_reg);
    assign rx_next = nxe8 - xlo8_reg;
    assign ry_next = nye8 - ylo8_reg;
    assign in_next = ok8_reg && (nxe8 >= xlo8_reg) && (nxe8 < xhi8_reg)
                     && (nye8 >= ylo8_reg) && (nye8 < yhi8_reg);

    // Divider: one quotient bit per stage for both coordinates.
    logic [RW-1:0] rx_reg [QB+1];
    logic [RW-1:0] ry_reg [QB+1];
    logic [QB-1:0] qx_reg [QB+1];
    logic [QB-1:0] qy_reg [QB+1];
    logic [DW-1:0] dv_reg [QB+1];
    logic          in_reg [QB+1];

    logic [RW-1:0] rx_next_a [QB];
    logic [RW-1:0] ry_next_a [QB];
    logic [QB-1:0] qx_next_a [QB];
    logic [QB-1:0] qy_next_a [QB];

    always_comb
    begin
        logic [RW-1:0] sh;
        sh = '0;
        for (int k = 0; k < QB; k++)
        begin
            sh = RW'(dv_reg[k]) << (QB - 1 - k);
            rx_next_a[k] = rx_reg[k];
            ry_next_a[k] = ry_reg[k];
            qx_next_a[k] = qx_reg[k];
            qy_next_a[k] = qy_reg[k];
            if (rx_reg[k] >= sh)
            begin
                rx_next_a[k] = rx_reg[k] - sh;
                qx_next_a[k][QB-1-k] = 1'b1;
            end
            if (ry_reg[k] >= sh)
            begin
                ry_next_a[k] = ry_reg[k] - sh;
                qy_next_a[k][QB-1-k] = 1'b1;
            end
        end
    end

    logic [prp_pkg::SX_W-1:0] sx_next;
    logic [prp_pkg::SY_W-1:0] sy_next;
    logic                     vis_next;

    assign vis_next = in_reg[QB];
    assign sx_next  = vis_next
                      ? prp_pkg::SX_W'(qx_reg[QB] + QB'(prp_pkg::X_MIN)) : '0;
    assign sy_next  = vis_next
                      ? prp_pkg::SY_W'(qy_reg[QB] + QB'(prp_pkg::Y_MIN)) : '0;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1a_reg <= vert_y * cfg_reg[prp_pkg::REG_COS_X];
            p1b_reg <= vert_z * cfg_reg[prp_pkg::REG_SIN_X];
            p1c_reg <= vert_y * cfg_reg[prp_pkg::REG_SIN_X];
            p1d_reg <= vert_z * cfg_reg[prp_pkg::REG_COS_X];
            x1_reg  <= vert_x;

            y2_reg <= s1a_next[R1+FB-1:FB];
            z2_reg <= s1b_next[R1+FB-1:FB];
            x2_reg <= x1_reg;

            p3a_reg <= PW2'(z2_reg) * PW2'(cfg_reg[prp_pkg::REG_COS_Y]);
            p3b_reg <= PW2'(x2_reg) * PW2'(cfg_reg[prp_pkg::REG_SIN_Y]);
            p3c_reg <= PW2'(z2_reg) * PW2'(cfg_reg[prp_pkg::REG_SIN_Y]);
            p3d_reg <= PW2'(x2_reg) * PW2'(cfg_reg[prp_pkg::REG_COS_Y]);
            y3_reg  <= y2_reg;

            z4_reg <= s3a_next[R2+FB-1:FB];
            x4_reg <= s3b_next[R2+FB-1:FB];
            y4_reg <= y3_reg;

            p5a_reg <= PW3'(x4_reg) * PW3'(cfg_reg[prp_pkg::REG_COS_Z]);
            p5b_reg <= PW3'(y4_reg) * PW3'(cfg_reg[prp_pkg::REG_SIN_Z]);
            p5c_reg <= PW3'(x4_reg) * PW3'(cfg_reg[prp_pkg::REG_SIN_Z]);
            p5d_reg <= PW3'(y4_reg) * PW3'(cfg_reg[prp_pkg::REG_COS_Z]);
            z5_reg  <= z4_reg;

            x6_reg <= s5a_next[R3+FB-1:FB];
            y6_reg <= s5b_next[R3+FB-1:FB];
            z6_reg <= z5_reg;

            depth7_reg <= depth_next;
            ok7_reg    <= (z6_reg <= R2'(cfg_reg[prp_pkg::REG_NEAR]))
                          && (depth_next > DW'(0));
            nx7_reg    <= NW'(x6_reg) * NW'(prp_pkg::FOCAL_LENGTH);
            ny7_reg    <= NW'(y6_reg) * NW'(4 * prp_pkg::FOCAL_LENGTH);

            xlo8_reg <= de7 * CW'(prp_pkg::QX_LO);
            xhi8_reg <= de7 * CW'(prp_pkg::QX_HI_P1);
            ylo8_reg <= de7 * CW'(prp_pkg::QY_LO);
            yhi8_reg <= de7 * CW'(prp_pkg::QY_HI_P1);
            nx8_reg  <= nx7_reg;
            ny8_reg  <= ny7_reg;
            d8_reg   <= depth7_reg;
            ok8_reg  <= ok7_reg;

            rx_reg[0] <= rx_next[RW-1:0];
            ry_reg[0] <= ry_next[RW-1:0];
            qx_reg[0] <= '0;
            qy_reg[0] <= '0;
            dv_reg[0] <= d8_reg;
            in_reg[0] <= in_next;

            for (int k = 0; k < QB; k++)
            begin
                rx_reg[k+1] <= rx_next_a[k];
                ry_reg[k+1] <= ry_next_a[k];
                qx_reg[k+1] <= qx_next_a[k];
                qy_reg[k+1] <= qy_next_a[k];
                dv_reg[k+1] <= dv_reg[k];
                in_reg[k+1] <= in_reg[k];
            end

            on_screen <= vis_next;
            screen_x  <= sx_next;
            screen_y  <= sy_next;
        end
    end

endmodule
